/* hw/rtl/fbfl_pkg.sv */
// Shared constants, types and helpers for the fixed block free list allocator.
package fbfl_pkg;

    // Pool geometry
    localparam int POOL_BLOCKS = 256;
    localparam int IDX_W       = $clog2(POOL_BLOCKS);
    localparam int LINK_W      = $clog2(POOL_BLOCKS + 1);
    localparam int LINK_END    = POOL_BLOCKS;

    // Counter store holds the free count over the allocation count
    localparam int CNT_W      = 32;
    localparam int CNT_PAIR_W = 2 * CNT_W;

    // Field widths
    localparam int BIU_W    = 9;
    localparam int BB_W     = 16;
    localparam int REQ_W    = 2;
    localparam int BIDX_W   = 8;
    localparam int STATUS_W = 2;
    localparam int RIDX_W   = 8;
    localparam int OFF_W    = 24;
    localparam int MDATA_W  = RIDX_W + OFF_W + 2 * CNT_W;

    // Configuration port
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int REG_SEL_W = 1;

    localparam logic [REG_SEL_W-1:0] REG_BLOCKS_IN_USE = 1'b0;
    localparam logic [REG_SEL_W-1:0] REG_BLOCK_BYTES   = 1'b1;

    localparam logic [BIU_W-1:0] BIU_RESET = 9'd256;
    localparam logic [BB_W-1:0]  BB_RESET  = 16'd64;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ALLOC  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REINIT = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP
    } state_t;

    typedef enum logic [2:0] {
        OP_ALLOC,
        OP_FREE,
        OP_EMPTY,
        OP_RANGE,
        OP_NOP
    } op_t;

    typedef struct packed {
        logic [BIU_W-1:0] blocks_in_use;
        logic [BB_W-1:0]  block_bytes;
    } cfg_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [LINK_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } link_req_t;

    typedef struct packed {
        logic                  we;
        logic [IDX_W-1:0]      waddr;
        logic [CNT_PAIR_W-1:0] wdata;
        logic                  re;
        logic [IDX_W-1:0]      raddr;
    } cnt_req_t;

    // Clamp the block count to 1..POOL_BLOCKS
    function automatic logic [LINK_W-1:0] eff_blocks(input logic [BIU_W-1:0] biu);
        logic [31:0] b;
        b = 32'(biu);
        if (b == 32'd0)
        begin
            b = 32'd1;
        end
        if (b > 32'(POOL_BLOCKS))
        begin
            b = 32'(POOL_BLOCKS);
        end
        return LINK_W'(b);
    endfunction

endpackage

/* hw/rtl/fbfl_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module fbfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/fbfl_cfg.sv */
// APB register file for the pool size and block size.
module fbfl_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fbfl_pkg::APB_AW-1:0]  paddr,
    input  logic [fbfl_pkg::APB_DW-1:0]  pwdata,
    output logic [fbfl_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output fbfl_pkg::cfg_t               cfg
);
    import fbfl_pkg::*;

    logic [BIU_W-1:0]     blocks_in_use_reg;
    logic [BB_W-1:0]      block_bytes_reg;
    logic [REG_SEL_W-1:0] reg_sel;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_sel = paddr[APB_AW-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blocks_in_use_reg <= BIU_RESET;
            block_bytes_reg   <= BB_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_BLOCKS_IN_USE: blocks_in_use_reg <= pwdata[BIU_W-1:0];
                REG_BLOCK_BYTES:   block_bytes_reg   <= pwdata[BB_W-1:0];
                default:           ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_sel)
            REG_BLOCKS_IN_USE: prdata = APB_DW'(blocks_in_use_reg);
            REG_BLOCK_BYTES:   prdata = APB_DW'(block_bytes_reg);
            default:           prdata = '0;
        endcase
    end

    assign cfg.blocks_in_use = blocks_in_use_reg;
    assign cfg.block_bytes   = block_bytes_reg;

endmodule

/* hw/rtl/fbfl_ctrl.sv */
// Request sequencer: reads, updates and writes back the link and counter RAMs.
module fbfl_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fbfl_pkg::cfg_t                  cfg,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [fbfl_pkg::BIDX_W-1:0]     s_axis_tdata,
    input  logic [fbfl_pkg::REQ_W-1:0]      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [fbfl_pkg::MDATA_W-1:0]    m_axis_tdata,
    output logic [fbfl_pkg::STATUS_W-1:0]   m_axis_tuser,
    output fbfl_pkg::link_req_t             link_req,
    input  logic [fbfl_pkg::LINK_W-1:0]     link_rdata,
    output fbfl_pkg::cnt_req_t              cnt_req,
    input  logic [fbfl_pkg::CNT_PAIR_W-1:0] cnt_rdata
);
    import fbfl_pkg::*;

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [BIDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic               empty_reg, empty_next;
    logic [IDX_W-1:0]   sweep_idx_reg, sweep_idx_next;
    logic [LINK_W-1:0]  sweep_blocks_reg, sweep_blocks_next;
    logic               out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [RIDX_W-1:0]  out_ridx_reg, out_ridx_next;
    logic [OFF_W-1:0]   out_off_reg, out_off_next;
    logic [CNT_W-1:0]   out_at_reg, out_at_next;
    logic [CNT_W-1:0]   out_ft_reg, out_ft_next;
    logic               out_load;

    logic               sweep_last;
    logic [LINK_W-1:0]  sweep_succ;
    logic [LINK_W-1:0]  sweep_link;
    logic [IDX_W-1:0]   res_idx;
    logic [IDX_W+BB_W-1:0] res_prod;
    logic [CNT_W-1:0]   alloc_inc;
    logic [CNT_W-1:0]   free_inc;
    logic               free_in_range;

    // Sweep link value: chain to the next block inside the pool, else end mark
    assign sweep_last = (sweep_idx_reg == IDX_W'(POOL_BLOCKS - 1));
    assign sweep_succ = LINK_W'(sweep_idx_reg) + LINK_W'(1);
    assign sweep_link = (sweep_succ < sweep_blocks_reg) ? sweep_succ : LINK_W'(LINK_END);

    // Block touched in the execute cycle and its byte offset
    assign res_idx   = (op_reg == OP_ALLOC) ? head_reg : IDX_W'(idx_reg);
    assign res_prod  = (IDX_W+BB_W)'(res_idx) * (IDX_W+BB_W)'(cfg.block_bytes);
    assign alloc_inc = cnt_rdata[CNT_W-1:0] + CNT_W'(1);
    assign free_inc  = cnt_rdata[CNT_PAIR_W-1:CNT_W] + CNT_W'(1);

    assign free_in_range = (32'(s_axis_tdata) < 32'(eff_blocks(cfg.blocks_in_use)));

    // Next state, memory requests and result
    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        idx_next          = idx_reg;
        head_next         = head_reg;
        empty_next        = empty_reg;
        sweep_idx_next    = sweep_idx_reg;
        sweep_blocks_next = sweep_blocks_reg;
        out_load          = 1'b0;
        out_status_next   = STATUS_OK;
        out_ridx_next     = '0;
        out_off_next      = '0;
        out_at_next       = '0;
        out_ft_next       = '0;
        link_req          = '0;
        cnt_req           = '0;
        s_axis_tready     = 1'b0;

        case (state_reg)
            ST_INIT, ST_SWEEP:
            begin
                // Write one entry of the fresh chain and clear its counters
                link_req.we    = 1'b1;
                link_req.waddr = sweep_idx_reg;
                link_req.wdata = sweep_link;
                cnt_req.we     = 1'b1;
                cnt_req.waddr  = sweep_idx_reg;
                cnt_req.wdata  = '0;
                if (sweep_last)
                begin
                    sweep_idx_next = '0;
                    state_next     = (state_reg == ST_INIT) ? ST_IDLE : ST_EXEC;
                end
                else
                begin
                    sweep_idx_next = sweep_idx_reg + IDX_W'(1);
                end
            end

            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    idx_next   = s_axis_tdata;
                    state_next = ST_EXEC;
                    case (s_axis_tuser)
                        REQ_ALLOC:
                        begin
                            if (empty_reg)
                            begin
                                op_next = OP_EMPTY;
                            end
                            else
                            begin
                                // Fetch the head's link and counters
                                op_next        = OP_ALLOC;
                                link_req.re    = 1'b1;
                                link_req.raddr = head_reg;
                                cnt_req.re     = 1'b1;
                                cnt_req.raddr  = head_reg;
                            end
                        end
                        REQ_FREE:
                        begin
                            if (free_in_range)
                            begin
                                op_next       = OP_FREE;
                                cnt_req.re    = 1'b1;
                                cnt_req.raddr = IDX_W'(s_axis_tdata);
                            end
                            else
                            begin
                                op_next = OP_RANGE;
                            end
                        end
                        REQ_REINIT:
                        begin
                            // Rebuild the list over the current pool size
                            op_next           = OP_NOP;
                            head_next         = '0;
                            empty_next        = 1'b0;
                            sweep_blocks_next = eff_blocks(cfg.blocks_in_use);
                            sweep_idx_next    = '0;
                            state_next        = ST_SWEEP;
                        end
                        default:
                        begin
                            op_next = OP_NOP;
                        end
                    endcase
                end
            end

            ST_EXEC:
            begin
                // Hold until the result register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    case (op_reg)
                        OP_ALLOC:
                        begin
                            cnt_req.we    = 1'b1;
                            cnt_req.waddr = head_reg;
                            cnt_req.wdata = {cnt_rdata[CNT_PAIR_W-1:CNT_W], alloc_inc};
                            if (link_rdata >= LINK_W'(LINK_END))
                            begin
                                empty_next = 1'b1;
                                head_next  = '0;
                            end
                            else
                            begin
                                head_next = link_rdata[IDX_W-1:0];
                            end
                            out_ridx_next = RIDX_W'(res_idx);
                            out_off_next  = OFF_W'(res_prod);
                            out_at_next   = alloc_inc;
                            out_ft_next   = cnt_rdata[CNT_PAIR_W-1:CNT_W];
                        end
                        OP_FREE:
                        begin
                            // Push the block in front of the old head
                            link_req.we    = 1'b1;
                            link_req.waddr = res_idx;
                            link_req.wdata = empty_reg ? LINK_W'(LINK_END) : LINK_W'(head_reg);
                            cnt_req.we     = 1'b1;
                            cnt_req.waddr  = res_idx;
                            cnt_req.wdata  = {free_inc, cnt_rdata[CNT_W-1:0]};
                            head_next      = res_idx;
                            empty_next     = 1'b0;
                            out_ridx_next  = RIDX_W'(res_idx);
                            out_off_next   = OFF_W'(res_prod);
                            out_at_next    = cnt_rdata[CNT_W-1:0];
                            out_ft_next    = free_inc;
                        end
                        OP_EMPTY:
                        begin
                            out_status_next = STATUS_EMPTY;
                        end
                        OP_RANGE:
                        begin
                            out_status_next = STATUS_RANGE;
                            out_ridx_next   = RIDX_W'(idx_reg);
                        end
                        default:
                        begin
                            out_status_next = STATUS_OK;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    // Result register valid
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_INIT;
            op_reg           <= OP_NOP;
            head_reg         <= '0;
            empty_reg        <= 1'b0;
            sweep_idx_reg    <= '0;
            sweep_blocks_reg <= eff_blocks(BIU_RESET);
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            op_reg           <= op_next;
            head_reg         <= head_next;
            empty_reg        <= empty_next;
            sweep_idx_reg    <= sweep_idx_next;
            sweep_blocks_reg <= sweep_blocks_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (out_load)
        begin
            out_status_reg <= out_status_next;
            out_ridx_reg   <= out_ridx_next;
            out_off_reg    <= out_off_next;
            out_at_reg     <= out_at_next;
            out_ft_reg     <= out_ft_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {out_ft_reg, out_at_reg, out_off_reg, out_ridx_reg};

    // An item always moves to execute or to the rebuild sweep
    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == ST_EXEC || state_reg == ST_SWEEP))
        else $error("accepted item did not advance");

    // An allocation is only executed on a non-empty list
    a_alloc_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && op_reg == OP_ALLOC) |-> !empty_reg)
        else $error("allocation executed on empty list");

    // Allocation never rewrites a link entry
    a_alloc_no_link_wr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && op_reg == OP_ALLOC) |-> !link_req.we)
        else $error("allocation wrote the link store");

    // A result is loaded only into a free or draining output register
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || m_axis_tready))
        else $error("result register overwritten");

    // The rebuild sweep ends in the execute cycle that reports it
    a_sweep_report: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP && sweep_last) |=> (state_reg == ST_EXEC && op_reg == OP_NOP))
        else $error("rebuild sweep did not report");

endmodule

/* hw/rtl/fixed_block_free_list_allocator_core.sv */
// Top level of the fixed block free list allocator: config regs, sequencer, RAMs.
//
//  Port group   Role     Contents
//  s_axis_*     in       tuser: req_type; tdata: block_index
//  m_axis_*     out      tuser: status; tdata: result_index, block_offset, totals
//  APB          config   0x0 blocks_in_use, 0x4 block_bytes
//
//  Allocate and free: the accept cycle issues the RAM reads (link and counter RAMs
//  for allocate, counter RAM only for free); the execute state then writes back
//  and loads the result register. Reinitialize sweeps every RAM entry, one RAM
//  entry per sweep cycle. After reset a clearing pass rebuilds the list; no item
//  is accepted then, config writes are. A result waiting on m_axis_tready does
//  not block accepting the next item; its write-back waits for the register to free.
module fixed_block_free_list_allocator_core (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input items
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [fbfl_pkg::BIDX_W-1:0]   s_axis_tdata,  // [7:0] block_index
    input  logic [fbfl_pkg::REQ_W-1:0]    s_axis_tuser,  // [1:0] req_type
    // Result items
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] result_index, [31:8] block_offset, [63:32] alloc_total, [95:64] free_total
    output logic [fbfl_pkg::MDATA_W-1:0]  m_axis_tdata,
    output logic [fbfl_pkg::STATUS_W-1:0] m_axis_tuser,  // [1:0] status
    // Configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fbfl_pkg::APB_AW-1:0]   paddr,
    input  logic [fbfl_pkg::APB_DW-1:0]   pwdata,
    output logic [fbfl_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import fbfl_pkg::*;

    cfg_t                  cfg;
    link_req_t             link_req;
    cnt_req_t              cnt_req;
    logic [LINK_W-1:0]     link_rdata;
    logic [CNT_PAIR_W-1:0] cnt_rdata;

    // Configuration registers
    fbfl_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Request sequencer
    fbfl_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .link_req      (link_req),
        .link_rdata    (link_rdata),
        .cnt_req       (cnt_req),
        .cnt_rdata     (cnt_rdata)
    );

    // Next-link store
    fbfl_ram #(
        .WIDTH (LINK_W),
        .DEPTH (POOL_BLOCKS)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_req.we),
        .waddr (link_req.waddr),
        .wdata (link_req.wdata),
        .re    (link_req.re),
        .raddr (link_req.raddr),
        .rdata (link_rdata)
    );

    // Per-block free and allocation counters
    fbfl_ram #(
        .WIDTH (CNT_PAIR_W),
        .DEPTH (POOL_BLOCKS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_req.we),
        .waddr (cnt_req.waddr),
        .wdata (cnt_req.wdata),
        .re    (cnt_req.re),
        .raddr (cnt_req.raddr),
        .rdata (cnt_rdata)
    );

endmodule
